/* rtl/cancellable_fifo_queue_unit_defines.svh */
// assertion macros used by the cancellable fifo queue datapath
`ifndef CANCELLABLE_FIFO_QUEUE_UNIT_DEFINES_SVH
`define CANCELLABLE_FIFO_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CFQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CFQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cfq_pkg.sv */
// shared types and constants of the cancellable fifo queue
package cfq_pkg;

  localparam int DEPTH     = 64;
  localparam int CODE_BITS = 16;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // fixed field widths of the word formats
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_TAKE   = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [CODE_BITS-1:0] user_code;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CODE_BITS-1:0] removed_code;
    logic [POS_W-1:0]     found_position;
    logic [COUNT_W-1:0]   entry_count;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    cap;
    logic    do_add;
    logic    rd_en;
    logic    set_shift;
    logic    wr_shift;
    logic    dec;
    logic    res;
    status_e res_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            rvalid;
    logic            hit;
    logic            last;
    logic            issue_ok;
  } stat_t;

endpackage

/* rtl/cfq_datapath.sv */
// entry store, count, scan and shift pointers and result register
`include "cancellable_fifo_queue_unit_defines.svh"

module cfq_datapath import cfq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cmd_t    cmd_i,
  output stat_t   stat_o,
  output logic    done_o,
  output result_t result_o
);

  logic [CODE_BITS-1:0] mem [DEPTH];

  logic [OP_W-1:0]      op_q;
  logic [CODE_BITS-1:0] code_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [ADDR_W-1:0]    raddr_q, raddr_d;
  logic                 rvalid_q, rvalid_d;
  logic [CODE_BITS-1:0] rd_data_q;
  logic [CODE_BITS-1:0] removed_q, removed_d;
  logic [ADDR_W-1:0]    pos_q, pos_d;
  logic                 done_q;
  result_t              result_q;

  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [CODE_BITS-1:0] wr_data;
  logic [CNT_W-1:0]     cnt_m1;

  assign cnt_m1 = count_q - CNT_W'(1);

  // one write port: append or move toward the front
  always_comb begin
    wr_en   = cmd_i.do_add | cmd_i.wr_shift;
    wr_addr = cmd_i.do_add ? count_q[ADDR_W-1:0] : (raddr_q - ADDR_W'(1));
    wr_data = cmd_i.do_add ? code_q : rd_data_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[idx_q[ADDR_W-1:0]];
    end
  end

  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    raddr_d   = raddr_q;
    rvalid_d  = cmd_i.rd_en;
    removed_d = removed_q;
    pos_d     = pos_q;
    if (cmd_i.rd_en) begin
      idx_d   = idx_q + CNT_W'(1);
      raddr_d = idx_q[ADDR_W-1:0];
    end
    if (cmd_i.set_shift) begin
      idx_d    = CNT_W'(raddr_q) + CNT_W'(1);
      rvalid_d = 1'b0;
      pos_d    = raddr_q;
      if (op_q == OP_TAKE) begin
        removed_d = rd_data_q;
      end
    end
    if (cmd_i.cap) begin
      idx_d     = '0;
      rvalid_d  = 1'b0;
      removed_d = '0;
      pos_d     = '0;
    end
    if (cmd_i.do_add) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.dec) begin
      count_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
      done_q   <= cmd_i.res;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q   <= raddr_d;
    removed_q <= removed_d;
    pos_q     <= pos_d;
    if (cmd_i.cap) begin
      op_q   <= item_i.op;
      code_q <= item_i.user_code;
    end
    if (cmd_i.res) begin
      result_q.status         <= cmd_i.res_status;
      result_q.removed_code   <= removed_q;
      result_q.found_position <= POS_W'(pos_q);
      result_q.entry_count    <= COUNT_W'(count_q);
    end
  end

  always_comb begin
    stat_o.op       = op_q;
    stat_o.full     = (count_q >= CNT_W'(DEPTH));
    stat_o.empty    = (count_q == '0);
    stat_o.rvalid   = rvalid_q;
    stat_o.hit      = (op_q == OP_TAKE) || (rd_data_q == code_q);
    stat_o.last     = (CNT_W'(raddr_q) == cnt_m1);
    stat_o.issue_ok = (idx_q < count_q);
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `CFQ_ASSERT_IMP(a_count_in_range, 1'b1, count_q <= CNT_W'(DEPTH), "count beyond depth")
  `CFQ_ASSERT_IMP(a_shift_has_data, cmd_i.wr_shift, rvalid_q && (raddr_q != '0),
                  "shift write without a read behind it")
  `CFQ_ASSERT_IMP(a_add_not_full, cmd_i.do_add, count_q < CNT_W'(DEPTH), "append into full store")
  `CFQ_ASSERT_NXT(a_dec_nonzero, cmd_i.dec, count_q == $past(count_q) - CNT_W'(1),
                  "count drop not by one")

endmodule

/* rtl/cfq_ctrl.sv */
// sequencing state machine of the cancellable fifo queue
module cfq_ctrl import cfq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output logic  busy_o,
  output cmd_t  cmd_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_DONE;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        unique case (stat_i.op)
          OP_ADD: begin
            st_d = stat_i.full ? ST_FULL : ST_DONE;
          end
          OP_TAKE: begin
            st_d = ST_EMPTY;
            if (!stat_i.empty) begin
              state_d = S_SCAN;
            end
          end
          OP_CANCEL: begin
            st_d = ST_NOT_FOUND;
            if (!stat_i.empty) begin
              state_d = S_SCAN;
            end
          end
          default: begin
            st_d = ST_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.rvalid && stat_i.hit) begin
          st_d    = ST_DONE;
          state_d = stat_i.last ? S_RESP : S_SHIFT;
        end else if (stat_i.rvalid && stat_i.last) begin
          st_d    = ST_NOT_FOUND;
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (stat_i.rvalid && stat_i.last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = st_q;
    busy_o           = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.cap = start_i;
      end
      S_EXEC: begin
        cmd_o.do_add = (stat_i.op == OP_ADD) && !stat_i.full;
        cmd_o.rd_en  = ((stat_i.op == OP_TAKE) || (stat_i.op == OP_CANCEL)) && !stat_i.empty;
      end
      S_SCAN: begin
        cmd_o.rd_en = stat_i.issue_ok;
        if (stat_i.rvalid && stat_i.hit) begin
          cmd_o.set_shift = 1'b1;
          cmd_o.dec       = stat_i.last;
        end
      end
      S_SHIFT: begin
        cmd_o.rd_en = stat_i.issue_ok;
        if (stat_i.rvalid) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.dec      = stat_i.last;
        end
      end
      S_RESP: begin
        cmd_o.res = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* rtl/cancellable_fifo_queue_unit.sv */
// top level of the cancellable fifo queue: ordered code store with removal by key
//
//   port         dir  handshake           word
//   item_i       in   start / busy        op, user_code
//   result_o     out  done_o strobe       status, removed_code, found_position, entry_count
//
// add and ops with the unused code pass from start through EXEC and RESP to the done_o strobe
// take and cancel also scan the queue for the key and shift the entries behind the hit toward the front:
// the single read port of the entry store walks over the queue, one entry a cycle but for a re-read after a hit
// reset clears the count and the controller; the store itself needs no clearing
// done_o is high for one cycle and cannot be held off; busy drops in that same cycle
module cancellable_fifo_queue_unit import cfq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: decode, scan for the key, close the gap, answer
  cfq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // entry store, count, pointers and result register
  cfq_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
